### rtl/sum_segment_tree_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros for the segment tree block
// Shared property forms used by the port checker.
// ----------------------------------------------------------------------------
`ifndef SUM_SEGMENT_TREE_MACROS_SVH
`define SUM_SEGMENT_TREE_MACROS_SVH

// Next-cycle implication that is switched off while reset is high.
`define SST_ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("sum_segment_tree: assertion failed");

// Next-cycle implication that is checked through reset as well.
`define SST_ASSERT_NEXT_RST(label, clk, ante, cons) \
  label: assert property (@(posedge clk) (ante) |=> (cons)) \
    else $error("sum_segment_tree: reset assertion failed");

`endif

### rtl/sst_pkg.sv
// ----------------------------------------------------------------------------
// sst_pkg
// Sizes, codes and shared types of the segment tree block.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package sst_pkg;

  // Tree geometry.
  localparam int MAX_LEAVES = 1024;
  localparam int VALUE_W    = 32;
  localparam int NODES      = 2 * MAX_LEAVES;
  localparam int NODE_W     = $clog2(NODES);
  localparam int IDX_W      = $clog2(MAX_LEAVES);
  localparam int CNT_W      = 11;
  localparam int LEVELS     = IDX_W;
  localparam int LVL_W      = $clog2(LEVELS + 1);

  localparam logic [CNT_W-1:0] LEAF_COUNT_RESET = CNT_W'(MAX_LEAVES);

  // Command codes of an input word.
  typedef enum logic {
    CMD_UPDATE = 1'b0,
    CMD_QUERY  = 1'b1
  } cmd_t;

  // Sequencer states.
  typedef enum logic [3:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_UP_LEAF_RD,
    ST_UP_LEAF_WR,
    ST_UP_SIB_RD,
    ST_UP_PAR_WR,
    ST_Q_RD,
    ST_Q_ACC,
    ST_Q_DONE
  } state_t;

  // Request from the sequencer to the node memory.
  typedef struct packed {
    logic              we;
    logic [NODE_W-1:0] waddr;
    logic [VALUE_W-1:0] wdata;
    logic [NODE_W-1:0] raddr;
  } ram_req_t;

endpackage

### rtl/sst_ram.sv
// ----------------------------------------------------------------------------
// sst_ram
// Node memory: one write port and one read port with registered read data.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module sst_ram (
  input  logic                          clk,
  input  sst_pkg::ram_req_t             req,
  output logic [sst_pkg::VALUE_W-1:0]   rdata
);

  logic [sst_pkg::VALUE_W-1:0] mem [0:sst_pkg::NODES-1];

  // Write port.
  always_ff @(posedge clk) begin
    if (req.we) begin
      mem[req.waddr] <= req.wdata;
    end
  end

  // Registered read port.
  always_ff @(posedge clk) begin
    rdata <= mem[req.raddr];
  end

endmodule

### rtl/sst_engine.sv
// ----------------------------------------------------------------------------
// sst_engine
// Sequencer and datapath that walk the tree with one shared adder.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module sst_engine (
  input  logic                                clk,
  input  logic                                rst,
  input  logic [sst_pkg::CNT_W-1:0]           n_leaves,
  input  logic                                in_valid,
  input  logic                                command,
  input  logic [sst_pkg::IDX_W-1:0]           index,
  input  logic [sst_pkg::IDX_W-1:0]           right_bound,
  input  logic signed [sst_pkg::VALUE_W-1:0]  delta,
  output logic                                in_stall,
  input  logic                                out_free,
  output logic                                res_load,
  output logic [sst_pkg::VALUE_W-1:0]         res_value,
  output sst_pkg::ram_req_t                   ram_req,
  input  logic [sst_pkg::VALUE_W-1:0]         ram_rdata
);

  sst_pkg::state_t state, state_next;

  logic [sst_pkg::NODE_W-1:0]  node, node_next;
  logic [sst_pkg::NODE_W:0]    left, left_next;
  logic [sst_pkg::NODE_W-1:0]  right, right_next;
  logic [sst_pkg::VALUE_W-1:0] acc, acc_next;

  logic [sst_pkg::VALUE_W-1:0] sum;
  logic [sst_pkg::CNT_W-1:0]   n_last;
  logic [sst_pkg::NODE_W-1:0]  lo_clamp, hi_clamp;
  logic                        upd_in_range;
  logic                        q_empty;
  logic [sst_pkg::NODE_W:0]    run_len;
  logic [sst_pkg::LEVELS:1]    climb_ok;
  logic [sst_pkg::LVL_W-1:0]   climb;
  logic [sst_pkg::NODE_W-1:0]  blk_node;
  logic [sst_pkg::NODE_W:0]    blk_span;

  // The one shared adder: leaf plus delta, child plus sibling, or running sum.
  assign sum = acc + ram_rdata;

  // Bounds of an incoming word under the current layout.
  always_comb begin
    n_last       = n_leaves - sst_pkg::CNT_W'(1);
    upd_in_range = {1'b0, index} < n_leaves;
    q_empty      = index > right_bound;
    lo_clamp     = ({1'b0, index} > n_last) ? n_last : {1'b0, index};
    hi_clamp     = ({1'b0, right_bound} > n_last) ? n_last : {1'b0, right_bound};
  end

  // Largest aligned block at the left end that still fits in the range.
  // Each level is checked on its own; the checks pass for a prefix of levels.
  always_comb begin
    run_len = {1'b0, right} - left + (sst_pkg::NODE_W + 1)'(1);
    for (int j = 1; j <= sst_pkg::LEVELS; j++) begin
      climb_ok[j] = ((left[sst_pkg::NODE_W-1:0] & sst_pkg::NODE_W'((1 << j) - 1)) == '0)
                    && (run_len >= ((sst_pkg::NODE_W + 1)'(1) << j));
    end
    climb    = sst_pkg::LVL_W'($countones(climb_ok));
    blk_node = left[sst_pkg::NODE_W-1:0] >> climb;
    blk_span = (sst_pkg::NODE_W + 1)'(1) << climb;
  end

  // Next state.
  always_comb begin
    state_next = state;
    case (state)
      sst_pkg::ST_CLEAR: begin
        if (node == '1) state_next = sst_pkg::ST_IDLE;
      end
      sst_pkg::ST_IDLE: begin
        if (in_valid) begin
          if (command == sst_pkg::CMD_QUERY) begin
            state_next = q_empty ? sst_pkg::ST_Q_DONE : sst_pkg::ST_Q_RD;
          end else if (upd_in_range) begin
            state_next = sst_pkg::ST_UP_LEAF_RD;
          end
        end
      end
      sst_pkg::ST_UP_LEAF_RD: state_next = sst_pkg::ST_UP_LEAF_WR;
      sst_pkg::ST_UP_LEAF_WR: begin
        state_next = (node > sst_pkg::NODE_W'(1)) ? sst_pkg::ST_UP_SIB_RD : sst_pkg::ST_IDLE;
      end
      sst_pkg::ST_UP_SIB_RD: state_next = sst_pkg::ST_UP_PAR_WR;
      sst_pkg::ST_UP_PAR_WR: begin
        state_next = ((node >> 1) > sst_pkg::NODE_W'(1)) ? sst_pkg::ST_UP_SIB_RD
                                                          : sst_pkg::ST_IDLE;
      end
      sst_pkg::ST_Q_RD: state_next = sst_pkg::ST_Q_ACC;
      sst_pkg::ST_Q_ACC: begin
        state_next = (left <= {1'b0, right}) ? sst_pkg::ST_Q_RD : sst_pkg::ST_Q_DONE;
      end
      sst_pkg::ST_Q_DONE: begin
        if (out_free) state_next = sst_pkg::ST_IDLE;
      end
      default: state_next = sst_pkg::ST_IDLE;
    endcase
  end

  // Outputs: memory requests, handshake and result hand-off.
  always_comb begin
    ram_req.we    = 1'b0;
    ram_req.waddr = node;
    ram_req.wdata = sum;
    ram_req.raddr = node;
    case (state)
      sst_pkg::ST_CLEAR: begin
        ram_req.we    = 1'b1;
        ram_req.wdata = '0;
      end
      sst_pkg::ST_UP_LEAF_WR: ram_req.we = 1'b1;
      sst_pkg::ST_UP_SIB_RD:  ram_req.raddr = node ^ sst_pkg::NODE_W'(1);
      sst_pkg::ST_UP_PAR_WR: begin
        ram_req.we    = 1'b1;
        ram_req.waddr = node >> 1;
      end
      sst_pkg::ST_Q_RD:       ram_req.raddr = blk_node;
      default: ram_req.we = 1'b0;
    endcase
    in_stall  = (state != sst_pkg::ST_IDLE);
    res_load  = (state == sst_pkg::ST_Q_DONE) && out_free;
    res_value = acc;
  end

  // Datapath register updates.
  always_comb begin
    node_next  = node;
    left_next  = left;
    right_next = right;
    acc_next   = acc;
    case (state)
      sst_pkg::ST_CLEAR: node_next = node + sst_pkg::NODE_W'(1);
      sst_pkg::ST_IDLE: begin
        if (in_valid) begin
          if (command == sst_pkg::CMD_QUERY) begin
            acc_next   = '0;
            left_next  = {1'b0, lo_clamp + n_leaves};
            right_next = hi_clamp + n_leaves;
          end else begin
            acc_next  = delta;
            node_next = {1'b0, index} + n_leaves;
          end
        end
      end
      sst_pkg::ST_UP_LEAF_WR: acc_next = sum;
      sst_pkg::ST_UP_PAR_WR: begin
        acc_next  = sum;
        node_next = node >> 1;
      end
      sst_pkg::ST_Q_RD:  left_next = left + blk_span;
      sst_pkg::ST_Q_ACC: acc_next = sum;
      default: acc_next = acc;
    endcase
  end

  // Control state; the walk pointer doubles as the clearing address.
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= sst_pkg::ST_CLEAR;
      node  <= '0;
    end else begin
      state <= state_next;
      node  <= node_next;
    end
  end

  // Payload registers.
  always_ff @(posedge clk) begin
    left  <= left_next;
    right <= right_next;
    acc   <= acc_next;
  end

endmodule

### rtl/sum_segment_tree.sv
// ----------------------------------------------------------------------------
// sum_segment_tree
// Range-sum segment tree over up to 1024 leaves with a node memory that has
// one read port and one write port.
// ----------------------------------------------------------------------------
//  Channel   Signals                                         Direction
//  input     in_valid, in_stall, command, index,             in (stall out)
//            right_bound, delta
//  output    out_valid, out_stall, range_sum                 out (stall in)
//  config    cfg_we, cfg_wdata (leaf_count)                  in
//
//  After reset the node memory is zeroed; in_stall is high then.
//  An update reads and rewrites the leaf, then reads the sibling and writes the
//  parent for each tree level above the leaf (at most 10); a query adds one aligned
//  block at a time. Both are bound by the single read port of the node memory.
//  A held output word does not block the next input word; a later query waits.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module sum_segment_tree (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                cfg_we,
  input  logic [sst_pkg::CNT_W-1:0]           cfg_wdata,
  input  logic                                in_valid,
  output logic                                in_stall,
  input  logic                                command,
  input  logic [sst_pkg::IDX_W-1:0]           index,
  input  logic [sst_pkg::IDX_W-1:0]           right_bound,
  input  logic signed [sst_pkg::VALUE_W-1:0]  delta,
  output logic                                out_valid,
  input  logic                                out_stall,
  output logic signed [sst_pkg::VALUE_W-1:0]  range_sum
);

  logic [sst_pkg::CNT_W-1:0]   leaf_count;
  logic [sst_pkg::CNT_W-1:0]   n_leaves;
  logic                        out_free;
  logic                        res_load;
  logic [sst_pkg::VALUE_W-1:0] res_value;
  sst_pkg::ram_req_t           ram_req;
  logic [sst_pkg::VALUE_W-1:0] ram_rdata;

  // Leaf count register.
  always_ff @(posedge clk) begin
    if (rst) begin
      leaf_count <= sst_pkg::LEAF_COUNT_RESET;
    end else if (cfg_we) begin
      leaf_count <= cfg_wdata;
    end
  end

  // Zero acts as one leaf, and anything past the maximum acts as the maximum.
  always_comb begin
    if (leaf_count == '0) begin
      n_leaves = sst_pkg::CNT_W'(1);
    end else if (leaf_count > sst_pkg::CNT_W'(sst_pkg::MAX_LEAVES)) begin
      n_leaves = sst_pkg::CNT_W'(sst_pkg::MAX_LEAVES);
    end else begin
      n_leaves = leaf_count;
    end
  end

  // Output register; it can take a new word in the cycle the old one leaves.
  assign out_free = !out_valid || !out_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (res_load) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (res_load) begin
      range_sum <= res_value;
    end
  end

  sst_engine u_engine (
    .clk         (clk),
    .rst         (rst),
    .n_leaves    (n_leaves),
    .in_valid    (in_valid),
    .command     (command),
    .index       (index),
    .right_bound (right_bound),
    .delta       (delta),
    .in_stall    (in_stall),
    .out_free    (out_free),
    .res_load    (res_load),
    .res_value   (res_value),
    .ram_req     (ram_req),
    .ram_rdata   (ram_rdata)
  );

  sst_ram u_ram (
    .clk   (clk),
    .req   (ram_req),
    .rdata (ram_rdata)
  );

endmodule

### rtl/sst_checker.sv
// ----------------------------------------------------------------------------
// sst_checker
// Port-level checks of the segment tree block, bound to the top level.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "sum_segment_tree_macros.svh"

module sst_checker (
  input logic                                clk,
  input logic                                rst,
  input logic                                in_valid,
  input logic                                in_stall,
  input logic                                command,
  input logic                                out_valid,
  input logic                                out_stall,
  input logic signed [sst_pkg::VALUE_W-1:0]  range_sum
);

  logic upd_accept;
  logic qry_accept;

  // Accepted input words by command.
  assign upd_accept = in_valid && !in_stall && (command == sst_pkg::CMD_UPDATE);
  assign qry_accept = in_valid && !in_stall && (command == sst_pkg::CMD_QUERY);

  // A stalled output word stays and keeps its value.
  `SST_ASSERT_NEXT(a_out_hold, clk, rst, out_valid && out_stall, out_valid)
  `SST_ASSERT_NEXT(a_out_stable, clk, rst, out_valid && out_stall, $stable(range_sum))

  // An update never produces an output word.
  `SST_ASSERT_NEXT(a_update_silent, clk, rst, upd_accept && !out_valid, !out_valid)

  // An accepted query always keeps the block busy in the next cycle.
  `SST_ASSERT_NEXT(a_query_busy, clk, rst, qry_accept, in_stall)

  // Reset starts the clearing pass with no word pending.
  `SST_ASSERT_NEXT_RST(a_reset_clear, clk, rst, in_stall && !out_valid)

endmodule

bind sum_segment_tree sst_checker u_sst_checker (.*);
